/* hw/rtl/wpp_pkg.sv */
// Shared types, tags and codes for the WAV PCM16 stream parser.
// Used by wpp_parser, wpp_result_queue and wav_pcm16_stream_parser_unit.
`timescale 1ns / 1ps

package wpp_pkg;

	// result kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_FORMAT = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// file status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_WAVE  = 3'd1;
	localparam logic [2:0] ST_BAD_FMT   = 3'd2;
	localparam logic [2:0] ST_NO_DATA   = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;
	localparam logic [2:0] ST_SHORT_FMT = 3'd5;

	// big-endian view of the four ASCII tag bytes as they shift in
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] FMT_MIN_LEN = 32'd16;
	localparam logic [15:0] PCM_BITS    = 16'd16;

	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_CHDR = 3'd1,
		PH_SKIP = 3'd2,
		PH_FMT  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] sample_value;
		logic               channel_index;
		logic [1:0]         channel_count;
		logic [31:0]        sample_rate_hz;
		logic [2:0]         status_code;
		logic               run_last;
	} result_t;

	// results produced by one byte, in order
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} parse_out_t;

	function automatic result_t status_item(input logic [2:0] st);
		result_t r;
		r             = '0;
		r.kind        = KIND_STATUS;
		r.status_code = st;
		return r;
	endfunction

	function automatic result_t format_item(input logic [1:0] chc, input logic [31:0] rate);
		result_t r;
		r                = '0;
		r.kind           = KIND_FORMAT;
		r.channel_count  = chc;
		r.sample_rate_hz = rate;
		return r;
	endfunction

	function automatic result_t sample_item(input logic [15:0] smp, input logic chi);
		result_t r;
		r               = '0;
		r.kind          = KIND_SAMPLE;
		r.sample_value  = smp;
		r.channel_index = chi;
		return r;
	endfunction

endpackage

/* hw/rtl/wpp_parser.sv */
// Byte-level RIFF/WAVE chunk walker: parse state registers plus the
// per-byte next-state and result logic. Depends on wpp_pkg.
`timescale 1ns / 1ps

module wpp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          file_byte,
	input  logic                end_of_file,
	output wpp_pkg::parse_out_t res
);

	wpp_pkg::phase_t phase_q, phase_n;
	logic [3:0]  off_q, off_n;
	logic [31:0] id_q, id_n;
	logic [31:0] left_q, left_n;
	logic        pad_q, pad_n;
	logic [3:0]  fmt_off_q, fmt_off_n;
	logic [15:0] ch_q, ch_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] frames_q, frames_n;
	logic        cur_q, cur_n;
	logic [7:0]  low_q, low_n;
	logic        dec_q, dec_n;

	logic [31:0] len_w;
	logic        fmt_ok;
	logic [2:0]  eof_st;

	assign fmt_ok = (bits_q == wpp_pkg::PCM_BITS) && (ch_q == 16'd1 || ch_q == 16'd2);

	always_comb begin
		phase_n   = phase_q;
		off_n     = off_q;
		id_n      = id_q;
		left_n    = left_q;
		pad_n     = pad_q;
		fmt_off_n = fmt_off_q;
		ch_n      = ch_q;
		rate_n    = rate_q;
		bits_n    = bits_q;
		frames_n  = frames_q;
		cur_n     = cur_q;
		low_n     = low_q;
		dec_n     = dec_q;
		len_w     = (off_q == 4'd0) ? 32'd0 : left_q;
		eof_st    = wpp_pkg::ST_NO_DATA;
		res       = '0;

		if (!dec_q) begin
			unique case (phase_q)
				wpp_pkg::PH_HDR: begin
					id_n = {id_q[23:0], file_byte};
					if (off_q == 4'd3 && id_n != wpp_pkg::TAG_RIFF) begin
						res.r0    = wpp_pkg::status_item(wpp_pkg::ST_NOT_WAVE);
						res.count = 2'd1;
						dec_n     = 1'b1;
					end else if (off_q == 4'd11 && id_n != wpp_pkg::TAG_WAVE) begin
						res.r0    = wpp_pkg::status_item(wpp_pkg::ST_NOT_WAVE);
						res.count = 2'd1;
						dec_n     = 1'b1;
					end
					if (off_q >= 4'd11) begin
						phase_n = wpp_pkg::PH_CHDR;
						off_n   = 4'd0;
					end else begin
						off_n = off_q + 4'd1;
					end
				end
				wpp_pkg::PH_CHDR: begin
					if (off_q < 4'd4) begin
						id_n = {id_q[23:0], file_byte};
					end else begin
						len_w[{off_q[1:0], 3'b000} +: 8] = file_byte;
					end
					left_n = len_w;
					if (off_q == 4'd7) begin
						off_n = 4'd0;
						pad_n = len_w[0];
						if (id_q == wpp_pkg::TAG_FMT) begin
							if (len_w < wpp_pkg::FMT_MIN_LEN) begin
								res.r0    = wpp_pkg::status_item(wpp_pkg::ST_SHORT_FMT);
								res.count = 2'd1;
								dec_n     = 1'b1;
							end else begin
								fmt_off_n = 4'd0;
								phase_n   = wpp_pkg::PH_FMT;
							end
						end else if (id_q == wpp_pkg::TAG_DATA) begin
							if (!fmt_ok) begin
								res.r0    = wpp_pkg::status_item(wpp_pkg::ST_BAD_FMT);
								res.count = 2'd1;
								dec_n     = 1'b1;
							end else begin
								res.r0    = wpp_pkg::format_item(ch_q[1:0], rate_q);
								res.count = 2'd1;
								// frame is 2 or 4 bytes
								frames_n  = (ch_q == 16'd1) ? {1'b0, len_w[31:1]}
								                            : {2'b00, len_w[31:2]};
								cur_n     = 1'b0;
								phase_n   = wpp_pkg::PH_DATA;
								if (frames_n == 32'd0) begin
									res.r1    = wpp_pkg::status_item(wpp_pkg::ST_OK);
									res.count = 2'd2;
									dec_n     = 1'b1;
								end
							end
						end else begin
							phase_n = (len_w == 32'd0 && !len_w[0]) ? wpp_pkg::PH_CHDR
							                                         : wpp_pkg::PH_SKIP;
						end
					end else begin
						off_n = off_q + 4'd1;
					end
				end
				wpp_pkg::PH_SKIP: begin
					if (left_q != 32'd0) begin
						left_n = left_q - 32'd1;
					end else begin
						pad_n = 1'b0;
					end
					phase_n = (left_n == 32'd0 && !pad_n) ? wpp_pkg::PH_CHDR
					                                       : wpp_pkg::PH_SKIP;
					off_n   = 4'd0;
				end
				wpp_pkg::PH_FMT: begin
					case (fmt_off_q) inside
						4'd2:             ch_n = {8'h00, file_byte};
						4'd3:             ch_n[15:8] = file_byte;
						4'd4:             rate_n = {24'h00_0000, file_byte};
						4'd5, 4'd6, 4'd7: rate_n[{fmt_off_q[1:0], 3'b000} +: 8] = file_byte;
						4'd14:            bits_n = {8'h00, file_byte};
						4'd15:            bits_n[15:8] = file_byte;
						default:          ;
					endcase
					if (left_q != 32'd0) begin
						left_n = left_q - 32'd1;
					end
					if (fmt_off_q == 4'd15) begin
						phase_n = (left_n == 32'd0 && !pad_q) ? wpp_pkg::PH_CHDR
						                                       : wpp_pkg::PH_SKIP;
						off_n   = 4'd0;
					end else begin
						fmt_off_n = fmt_off_q + 4'd1;
					end
				end
				wpp_pkg::PH_DATA: begin
					if (!off_q[0]) begin
						low_n = file_byte;
						off_n = 4'd1;
					end else begin
						off_n     = 4'd0;
						res.r0    = wpp_pkg::sample_item({file_byte, low_q}, cur_q);
						res.count = 2'd1;
						if (ch_q == 16'd2 && !cur_q) begin
							cur_n = 1'b1;
						end else begin
							cur_n    = 1'b0;
							frames_n = frames_q - 32'd1;
							if (frames_n == 32'd0) begin
								res.r1    = wpp_pkg::status_item(wpp_pkg::ST_OK);
								res.count = 2'd2;
								dec_n     = 1'b1;
							end
						end
					end
				end
				default: begin
					phase_n = wpp_pkg::PH_HDR;
				end
			endcase
		end

		if (end_of_file) begin
			if (!dec_n) begin
				case (phase_n) inside
					wpp_pkg::PH_HDR:                  eof_st = wpp_pkg::ST_NOT_WAVE;
					wpp_pkg::PH_FMT, wpp_pkg::PH_DATA: eof_st = wpp_pkg::ST_TRUNCATED;
					default:                          eof_st = wpp_pkg::ST_NO_DATA;
				endcase
				if (res.count == 2'd0) begin
					res.r0 = wpp_pkg::status_item(eof_st);
				end else begin
					res.r1 = wpp_pkg::status_item(eof_st);
				end
				res.count = res.count + 2'd1;
			end
			// every file starts from a clean state
			phase_n   = wpp_pkg::PH_HDR;
			off_n     = 4'd0;
			id_n      = 32'd0;
			left_n    = 32'd0;
			pad_n     = 1'b0;
			fmt_off_n = 4'd0;
			ch_n      = 16'd0;
			rate_n    = 32'd0;
			bits_n    = 16'd0;
			frames_n  = 32'd0;
			cur_n     = 1'b0;
			low_n     = 8'd0;
			dec_n     = 1'b0;
		end

		if (res.count == 2'd1) begin
			res.r0.run_last = 1'b1;
		end else if (res.count == 2'd2) begin
			res.r1.run_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wpp_pkg::PH_HDR;
			off_q     <= 4'd0;
			id_q      <= 32'd0;
			left_q    <= 32'd0;
			pad_q     <= 1'b0;
			fmt_off_q <= 4'd0;
			ch_q      <= 16'd0;
			rate_q    <= 32'd0;
			bits_q    <= 16'd0;
			frames_q  <= 32'd0;
			cur_q     <= 1'b0;
			low_q     <= 8'd0;
			dec_q     <= 1'b0;
		end else if (take) begin
			phase_q   <= phase_n;
			off_q     <= off_n;
			id_q      <= id_n;
			left_q    <= left_n;
			pad_q     <= pad_n;
			fmt_off_q <= fmt_off_n;
			ch_q      <= ch_n;
			rate_q    <= rate_n;
			bits_q    <= bits_n;
			frames_q  <= frames_n;
			cur_q     <= cur_n;
			low_q     <= low_n;
			dec_q     <= dec_n;
		end
	end

	a_two_results_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.count == 2'd2 |-> !res.r0.run_last && res.r1.run_last)
		else $error("two results per byte but run_last misplaced");

	a_eof_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_file |=> phase_q == wpp_pkg::PH_HDR && !dec_q && off_q == 4'd0)
		else $error("state not cleared after end of file");

	a_status_decides: assert property (@(posedge clk) disable iff (!arst_n)
		take && !end_of_file && res.count != 2'd0 &&
		((res.count == 2'd1 && res.r0.kind == wpp_pkg::KIND_STATUS) ||
		 (res.count == 2'd2 && res.r1.kind == wpp_pkg::KIND_STATUS)) |=> dec_q)
		else $error("status emitted but file not marked decided");

	a_data_fmt_ok: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == wpp_pkg::PH_DATA |-> fmt_ok)
		else $error("data phase entered with unsupported format");

endmodule

/* hw/rtl/wpp_result_queue.sv */
// Three-entry shift queue for result items; takes up to two per cycle,
// presents one per cycle on the output channel while out_stall is low. Depends on wpp_pkg.
`timescale 1ns / 1ps

module wpp_result_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  wpp_pkg::parse_out_t push,
	input  logic                out_stall,
	output logic                out_valid,
	output wpp_pkg::result_t    head,
	output logic                room
);

	wpp_pkg::result_t slot_q [3];
	logic [1:0] count_q;
	logic [1:0] base;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign base      = count_q - {1'b0, pop};
	// at least two free entries after this cycle's pop
	assign room      = !base[1];
	assign head      = slot_q[0];

	// new results land at the first free entries after the shift
	always_ff @(posedge clk) begin
		if (push.count != 2'd0 && base == 2'd0) begin
			slot_q[0] <= push.r0;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
		end
		if (push.count != 2'd0 && base == 2'd1) begin
			slot_q[1] <= push.r0;
		end else if (push.count == 2'd2 && base == 2'd0) begin
			slot_q[1] <= push.r1;
		end else if (pop) begin
			slot_q[1] <= slot_q[2];
		end
		if (push.count == 2'd2 && base == 2'd1) begin
			slot_q[2] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= base + push.count;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> ({1'b0, base} + {1'b0, push.count}) <= 3'd3)
		else $error("result queue overflow");

	a_full_after_pair: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(count_q == 2'd3) |-> $past(push.count) == 2'd2)
		else $error("queue filled without a two-result byte");

endmodule

/* hw/rtl/wav_pcm16_stream_parser_unit.sv */
// WAV PCM16 stream parser, top level: input byte register, parser core and
// result queue. Depends on wpp_pkg, wpp_parser, wpp_result_queue.
//
// Usage: feed a RIFF/WAVE file one byte per in_valid/in_stall transaction,
// end_of_file high on its last byte. For each file the block emits one
// format item at the first data chunk if its format is supported, then
// interleaved signed Q15 samples, and always exactly one status item;
// run_last flags the last result that a byte caused. Results leave on
// the out_valid/out_stall channel. An accepted byte is held in the input
// byte register, parsed once the three-entry result queue has room and
// written to it; its head offers the first result. Throughput: one byte
// per cycle while in_stall is low; two results of one byte (format plus
// empty status, last sample plus status) leave in turn via the queue's output.
// When the receiver stalls, results collect in the queue and in_stall rises
// once the queue cannot take two more; nothing is dropped.
// Reset clears the parse state and both channels; the block then expects
// the RIFF tag at the next byte. end_of_file also returns it to that state.
`timescale 1ns / 1ps

module wav_pcm16_stream_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         file_byte,
	input  logic               end_of_file,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [15:0] sample_value,
	output logic               channel_index,
	output logic [1:0]         channel_count,
	output logic [31:0]        sample_rate_hz,
	output logic [2:0]         status_code,
	output logic               run_last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       room;
	logic       take;
	logic       in_fire;

	wpp_pkg::parse_out_t parsed;
	wpp_pkg::parse_out_t push;
	wpp_pkg::result_t    head;

	assign take     = valid_s1 && room;
	assign in_stall = valid_s1 && !take;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !take);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= file_byte;
			eof_s1  <= end_of_file;
		end
	end

	wpp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.file_byte   (byte_s1),
		.end_of_file (eof_s1),
		.res         (parsed)
	);

	// results only count for a byte actually consumed this cycle
	always_comb begin
		push = parsed;
		if (!take) begin
			push.count = 2'd0;
		end
	end

	wpp_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	assign kind           = head.kind;
	assign sample_value   = head.sample_value;
	assign channel_index  = head.channel_index;
	assign channel_count  = head.channel_count;
	assign sample_rate_hz = head.sample_rate_hz;
	assign status_code    = head.status_code;
	assign run_last       = head.run_last;

endmodule
